[rtl/core/hss_pkg.sv]
// ----------------------------------------------------------------------------
// hss_pkg
// shared types, codes and constants of the half-step stepper sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package hss_pkg;

   localparam int KIND_W   = 3;
   localparam int STEP_W   = 16;
   localparam int PERIOD_W = 24;
   localparam int PHASE_W  = 3;
   localparam int COILS_W  = 4;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam int DIVIDER_BITS_DEF = 24;

   localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TURN   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TARGET = 3'd2;
   localparam logic [KIND_W-1:0] KIND_STOP   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

   localparam logic REG_STEPS_PER_REV = 1'b0;
   localparam logic REG_STEP_PERIOD   = 1'b1;

   localparam logic [STEP_W-1:0]   STEPS_PER_REV_RST = 16'd4097;
   localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST   = 24'd125000;

   typedef struct packed {
      logic [STEP_W-1:0]   steps_per_rev;
      logic [PERIOD_W-1:0] step_period;
   } cfg_type;

   function automatic logic [COILS_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
      logic [COILS_W-1:0] pat;
      case (ph)
         3'd0: pat = 4'h1;
         3'd1: pat = 4'h3;
         3'd2: pat = 4'h2;
         3'd3: pat = 4'h6;
         3'd4: pat = 4'h4;
         3'd5: pat = 4'hC;
         3'd6: pat = 4'h8;
         3'd7: pat = 4'h9;
         default: pat = 4'h1;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

[rtl/core/half_step_stepper_sequencer.sv]
// ----------------------------------------------------------------------------
// half_step_stepper_sequencer
// four-coil stepper sequencer over the eight-phase half-step pattern
// ----------------------------------------------------------------------------
// Each request word is registered, applied to the motion state in one pass and
// answered by one response word showing the state after it. Tick, turn, stop
// and clear-position words go through at one word per clock cycle unless the
// response side stalls, with the response register able to hold a word while
// the next request is taken. A turn-to-target word waits while two bit-serial
// remainder units reduce target and position modulo steps per revolution.
// Registers are to be written only while idle; the block does not enforce it.
`default_nettype none

module half_step_stepper_sequencer #(
   parameter int DIVIDER_BITS = hss_pkg::DIVIDER_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [hss_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [hss_pkg::STEP_W-1:0]  req_step_count,
   input  wire logic                        req_clockwise,
   input  wire logic [hss_pkg::STEP_W-1:0]  req_target_step,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [hss_pkg::COILS_W-1:0] rsp_coils,
   output logic      [hss_pkg::STEP_W-1:0]  rsp_position,
   output logic      [hss_pkg::STEP_W-1:0]  rsp_remaining,
   output logic                             rsp_moving_clockwise,
   output logic                             rsp_busy_res,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [hss_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [hss_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [hss_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import hss_pkg::*;

   localparam int EW = DIVIDER_BITS + 1;

   cfg_type cfg;

   // request register
   logic              in_valid_ff;
   logic [KIND_W-1:0] in_kind_ff;
   logic [STEP_W-1:0] in_count_ff;
   logic              in_cw_ff;
   logic [STEP_W-1:0] in_target_ff;

   // motion state
   logic [PHASE_W-1:0]      phase_ff,  phase_in;
   logic [STEP_W-1:0]       pos_ff,    pos_in;
   logic [STEP_W-1:0]       togo_ff,   togo_in;
   logic                    dir_ff,    dir_in;
   logic [DIVIDER_BITS-1:0] tick_ff,   tick_in;

   // response register
   logic               rsp_valid_ff;
   logic [COILS_W-1:0] rsp_coils_ff;
   logic [STEP_W-1:0]  rsp_pos_ff;
   logic [STEP_W-1:0]  rsp_togo_ff;
   logic               rsp_dir_ff;
   logic               rsp_busy_ff;

   logic              issue_ff;
   logic              is_target;
   logic              rem_start;
   logic              tgt_done;
   logic              pos_done;
   logic [STEP_W-1:0] tgt_rem;
   logic [STEP_W-1:0] pos_rem;
   logic              out_free;
   logic              fire;
   logic [STEP_W-1:0] modulus;

   hss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign modulus = (cfg.steps_per_rev < STEP_W'(2)) ? STEP_W'(1) : cfg.steps_per_rev;

   assign is_target = (in_kind_ff == KIND_TARGET);
   assign rem_start = in_valid_ff && is_target && !issue_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free &&
                      (!is_target || (issue_ff && tgt_done && pos_done));
   assign req_ready = !in_valid_ff || fire;

   hss_rem u_rem_target (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (in_target_ff),
      .divisor   (modulus),
      .done      (tgt_done),
      .remainder (tgt_rem)
   );

   hss_rem u_rem_position (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (pos_ff),
      .divisor   (modulus),
      .done      (pos_done),
      .remainder (pos_rem)
   );

   // next motion state for the word in the request register
   always_comb begin
      logic [32:0]     per_ext;
      logic [32:0]     per_lim;
      logic [32:0]     per_eff;
      logic [EW-1:0]   eff;
      logic [EW-1:0]   tick_nx;
      logic [STEP_W:0] pos_inc;
      logic [STEP_W:0] sum;
      logic [STEP_W-1:0] base;
      logic signed [STEP_W+2:0] d_s;
      logic signed [STEP_W+2:0] dd_s;
      logic signed [STEP_W+2:0] m_s;
      logic signed [STEP_W+2:0] abs_s;

      phase_in = phase_ff;
      pos_in   = pos_ff;
      togo_in  = togo_ff;
      dir_in   = dir_ff;
      tick_in  = tick_ff;

      per_ext = {{(33-PERIOD_W){1'b0}}, cfg.step_period};
      if (per_ext == 33'd0) begin
         per_ext = 33'd1;
      end
      per_lim = 33'd1 << DIVIDER_BITS;
      per_eff = (per_ext > per_lim) ? per_lim : per_ext;
      eff     = per_eff[EW-1:0];
      tick_nx = {1'b0, tick_ff} + EW'(1);
      pos_inc = {1'b0, pos_ff} + (STEP_W+1)'(1);

      base = togo_ff;
      sum  = '0;
      m_s  = $signed({3'b000, modulus});
      d_s  = $signed({3'b000, tgt_rem}) - $signed({3'b000, pos_rem});
      dd_s = '0;
      abs_s = '0;

      case (in_kind_ff)
         KIND_TICK: begin
            if (togo_ff == '0) begin
               tick_in = '0;
            end else if (tick_nx >= eff) begin
               tick_in = '0;
               togo_in = togo_ff - STEP_W'(1);
               if (dir_ff) begin
                  phase_in = phase_ff + PHASE_W'(1);
                  pos_in   = (pos_inc >= {1'b0, modulus}) ? '0 : pos_inc[STEP_W-1:0];
               end else begin
                  phase_in = phase_ff - PHASE_W'(1);
                  if (pos_ff == '0 || pos_ff >= modulus) begin
                     pos_in = modulus - STEP_W'(1);
                  end else begin
                     pos_in = pos_ff - STEP_W'(1);
                  end
               end
            end else begin
               tick_in = tick_nx[DIVIDER_BITS-1:0];
            end
         end
         KIND_TURN: begin
            if (in_cw_ff != dir_ff) begin
               base    = '0;
               tick_in = '0;
               dir_in  = in_cw_ff;
            end
            sum     = {1'b0, base} + {1'b0, in_count_ff};
            togo_in = sum[STEP_W] ? {STEP_W{1'b1}} : sum[STEP_W-1:0];
         end
         KIND_TARGET: begin
            tick_in = '0;
            dd_s    = d_s <<< 1;
            if (dd_s < -m_s) begin
               d_s = d_s + m_s;
            end else if (dd_s > m_s) begin
               d_s = d_s - m_s;
            end
            abs_s   = (d_s < 0) ? -d_s : d_s;
            dir_in  = !(d_s < 0);
            togo_in = abs_s[STEP_W-1:0];
         end
         KIND_STOP: begin
            togo_in = '0;
            tick_in = '0;
         end
         KIND_CLEAR: begin
            pos_in = '0;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         pos_ff       <= '0;
         togo_ff      <= '0;
         dir_ff       <= 1'b1;
         tick_ff      <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            issue_ff <= 1'b0;
         end else if (rem_start) begin
            issue_ff <= 1'b1;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fire) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            togo_ff  <= togo_in;
            dir_ff   <= dir_in;
            tick_ff  <= tick_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_kind_ff   <= req_kind;
         in_count_ff  <= req_step_count;
         in_cw_ff     <= req_clockwise;
         in_target_ff <= req_target_step;
      end
      if (fire) begin
         rsp_coils_ff <= coil_pattern(phase_in);
         rsp_pos_ff   <= pos_in;
         rsp_togo_ff  <= togo_in;
         rsp_dir_ff   <= dir_in;
         rsp_busy_ff  <= (togo_in != '0);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_coils            = rsp_coils_ff;
   assign rsp_position         = rsp_pos_ff;
   assign rsp_remaining        = rsp_togo_ff;
   assign rsp_moving_clockwise = rsp_dir_ff;
   assign rsp_busy_res         = rsp_busy_ff;

endmodule

`default_nettype wire

[rtl/core/hss_csr.sv]
// ----------------------------------------------------------------------------
// hss_csr
// register port holding steps per revolution and step period
// ----------------------------------------------------------------------------
`default_nettype none

module hss_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [hss_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [hss_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [hss_pkg::CSR_DW-1:0] csr_prdata,
   output logic                            csr_pready,
   output hss_pkg::cfg_type                cfg
);
   import hss_pkg::*;

   logic [STEP_W-1:0]   spr_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic                wr_en;
   logic                reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff    <= STEPS_PER_REV_RST;
         period_ff <= STEP_PERIOD_RST;
      end else if (wr_en) begin
         if (reg_sel == REG_STEPS_PER_REV) begin
            spr_ff <= csr_pwdata[STEP_W-1:0];
         end else begin
            period_ff <= csr_pwdata[PERIOD_W-1:0];
         end
      end
   end

   always_comb begin
      if (reg_sel == REG_STEPS_PER_REV) begin
         csr_prdata = {{(CSR_DW-STEP_W){1'b0}}, spr_ff};
      end else begin
         csr_prdata = {{(CSR_DW-PERIOD_W){1'b0}}, period_ff};
      end
   end

   assign cfg.steps_per_rev = spr_ff;
   assign cfg.step_period   = period_ff;

endmodule

`default_nettype wire

[rtl/core/hss_rem.sv]
// ----------------------------------------------------------------------------
// hss_rem
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hss_rem (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [hss_pkg::STEP_W-1:0] dividend,
   input  wire logic [hss_pkg::STEP_W-1:0] divisor,
   output logic                            done,
   output logic      [hss_pkg::STEP_W-1:0] remainder
);
   import hss_pkg::*;

   localparam int CNT_W = $clog2(STEP_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [STEP_W-1:0] quo_ff;
   logic [STEP_W-1:0] div_ff;
   logic [STEP_W-1:0] rem_ff;
   logic [STEP_W-1:0] rem_in;
   logic [STEP_W:0]   shifted;
   logic [STEP_W:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[STEP_W-1]};
      diff    = shifted - {1'b0, div_ff};
      if (shifted >= {1'b0, div_ff}) begin
         rem_in = diff[STEP_W-1:0];
      end else begin
         rem_in = shifted[STEP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STEP_W-1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[STEP_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[tb/half_step_stepper_sequencer_tb.sv]
// ----------------------------------------------------------------------------
// half_step_stepper_sequencer_tb
// Self-checking bench for the half-step stepper sequencer. A clocked driver
// feeds request words from a backlog, and a model of the motion state
// predicts one status word per request. A clocked receiver compares each
// response field by field against the oldest prediction. A directed opening
// is followed by randomized turn, target, stop, clear, unused-kind and tick
// sequences under several step-per-revolution and step-period settings, with
// random gaps on both channels.
// ----------------------------------------------------------------------------

module half_step_stepper_sequencer_tb;
   import hss_pkg::*;

   localparam logic [KIND_W-1:0] KIND_LAST = 3'd7;
   localparam logic [31:0]       COIL_SEQ  = 32'h98C46231;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [STEP_W-1:0] step_count;
      logic              clockwise;
      logic [STEP_W-1:0] target_step;
   } motor_cmd_type;

   typedef struct packed {
      logic [COILS_W-1:0] coils;
      logic [STEP_W-1:0]  position;
      logic [STEP_W-1:0]  remaining;
      logic               moving_clockwise;
      logic               busy_res;
   } motor_status_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [STEP_W-1:0]   req_step_count = '0;
   logic                req_clockwise = 1'b0;
   logic [STEP_W-1:0]   req_target_step = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [COILS_W-1:0]  rsp_coils;
   logic [STEP_W-1:0]   rsp_position;
   logic [STEP_W-1:0]   rsp_remaining;
   logic                rsp_moving_clockwise;
   logic                rsp_busy_res;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   motor_cmd_type       cmd_backlog[$];
   motor_status_type    status_due[$];

   logic [STEP_W-1:0]   cfg_steps_per_rev = STEPS_PER_REV_RST;
   logic [PERIOD_W-1:0] cfg_step_period = STEP_PERIOD_RST;
   logic [PHASE_W-1:0]  mdl_phase = '0;
   logic [STEP_W-1:0]   mdl_position = '0;
   logic [STEP_W-1:0]   mdl_to_go = '0;
   logic                mdl_dir_cw = 1'b1;
   longint              mdl_ticks = 0;

   bit                  send_idle = 1'b1;
   bit                  recv_idle = 1'b1;
   int                  send_gap = 0;
   int                  recv_stall = 0;
   int                  hold_ask = 0;
   int                  hold_seen = 0;
   int                  hold_left = 0;
   int                  mismatches = 0;

   half_step_stepper_sequencer u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_step_count       (req_step_count),
      .req_clockwise        (req_clockwise),
      .req_target_step      (req_target_step),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_coils            (rsp_coils),
      .rsp_position         (rsp_position),
      .rsp_remaining        (rsp_remaining),
      .rsp_moving_clockwise (rsp_moving_clockwise),
      .rsp_busy_res         (rsp_busy_res),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #6 clock = ~clock;

   task automatic advance_motion(input motor_cmd_type cmd);
      int               m;
      int               d;
      int               sum;
      longint           eff;
      motor_status_type st;
      m = (cfg_steps_per_rev < 2) ? 1 : int'(cfg_steps_per_rev);
      case (cmd.kind)
         KIND_TICK: begin
            if (mdl_to_go == 0) begin
               mdl_ticks = 0;
            end else begin
               eff = (cfg_step_period == 0) ? 1 : longint'(cfg_step_period);
               if (eff > (longint'(1) << DIVIDER_BITS_DEF))
                  eff = longint'(1) << DIVIDER_BITS_DEF;
               if (mdl_ticks + 1 >= eff) begin
                  mdl_ticks = 0;
                  if (mdl_dir_cw) begin
                     mdl_phase = mdl_phase + 3'd1;
                     mdl_position = (int'(mdl_position) + 1 >= m) ? '0 : mdl_position + 16'd1;
                  end else begin
                     mdl_phase = mdl_phase - 3'd1;
                     mdl_position = (mdl_position == 0 || int'(mdl_position) >= m) ?
                                    STEP_W'(m - 1) : mdl_position - 16'd1;
                  end
                  mdl_to_go = mdl_to_go - 16'd1;
               end else begin
                  mdl_ticks = mdl_ticks + 1;
               end
            end
         end
         KIND_TURN: begin
            if (cmd.clockwise != mdl_dir_cw) begin
               mdl_to_go  = '0;
               mdl_ticks  = 0;
               mdl_dir_cw = cmd.clockwise;
            end
            sum = int'(mdl_to_go) + int'(cmd.step_count);
            mdl_to_go = (sum > 65535) ? {STEP_W{1'b1}} : STEP_W'(sum);
         end
         KIND_TARGET: begin
            d = int'(cmd.target_step) % m - int'(mdl_position) % m;
            mdl_ticks = 0;
            if (2 * d < -m)
               d = d + m;
            if (2 * d > m)
               d = d - m;
            mdl_dir_cw = (d >= 0);
            mdl_to_go  = STEP_W'((d < 0) ? -d : d);
         end
         KIND_STOP: begin
            mdl_to_go = '0;
            mdl_ticks = 0;
         end
         KIND_CLEAR: begin
            mdl_position = '0;
         end
         default: ;
      endcase
      st.coils            = COIL_SEQ[mdl_phase * 4 +: 4];
      st.position         = mdl_position;
      st.remaining        = mdl_to_go;
      st.moving_clockwise = mdl_dir_cw;
      st.busy_res         = (mdl_to_go != 0);
      status_due.push_back(st);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic queue_cmd(input logic [KIND_W-1:0] kind, input logic [STEP_W-1:0] count,
                            input logic cw, input logic [STEP_W-1:0] target);
      motor_cmd_type c;
      c.kind        = kind;
      c.step_count  = count;
      c.clockwise   = cw;
      c.target_step = target;
      cmd_backlog.push_back(c);
   endtask

   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || req_valid || status_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(input logic reg_idx, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(reg_idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_idx == REG_STEPS_PER_REV)
         cfg_steps_per_rev = value[STEP_W-1:0];
      else
         cfg_step_period = value[PERIOD_W-1:0];
   endtask

   // request word driver
   always @(posedge clock) begin : word_driver
      motor_cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            advance_motion({req_kind, req_step_count, req_clockwise, req_target_step});
         if (!req_valid || req_ready) begin
            if (send_gap != 0 || cmd_backlog.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap != 0)
                  send_gap = send_gap - 1;
            end else begin
               nxt = cmd_backlog.pop_front();
               req_valid       <= 1'b1;
               req_kind        <= nxt.kind;
               req_step_count  <= nxt.step_count;
               req_clockwise   <= nxt.clockwise;
               req_target_step <= nxt.target_step;
               send_gap = send_idle ? $urandom_range(0, 17) : 0;
            end
         end
      end
   end

   // response word receiver and checker
   always @(posedge clock) begin : word_receiver
      motor_status_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               $display("%0t: unexpected response word, expected none, actual pos %0d",
                        $time, rsp_position);
               mismatches++;
            end else begin
               want = status_due.pop_front();
               check_field("coils", 32'(want.coils), 32'(rsp_coils));
               check_field("position", 32'(want.position), 32'(rsp_position));
               check_field("remaining", 32'(want.remaining), 32'(rsp_remaining));
               check_field("moving_clockwise", 32'(want.moving_clockwise),
                           32'(rsp_moving_clockwise));
               check_field("busy_res", 32'(want.busy_res), 32'(rsp_busy_res));
            end
            recv_stall = recv_idle ? $urandom_range(0, 17) : 0;
         end
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = 80;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (recv_stall != 0) begin
            recv_stall = recv_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : run_sequence
      int                ph;
      int                half;
      int                made;
      int                n;
      int                sel;
      int                r;
      int                i;
      logic [STEP_W-1:0] count;
      logic [STEP_W-1:0] tgt;
      logic [KIND_W-1:0] kind;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: saturation, direction change, target folding, unused kind
      queue_cmd(KIND_TICK, '0, 1'b0, '0);
      queue_cmd(KIND_TURN, '0, 1'b1, '0);
      queue_cmd(KIND_TURN, 16'hFFFF, 1'b1, '0);
      queue_cmd(KIND_TURN, 16'd1, 1'b1, '0);
      queue_cmd(KIND_TICK, '0, 1'b0, '0);
      queue_cmd(KIND_TURN, 16'd7, 1'b0, '0);
      queue_cmd(KIND_STOP, '0, 1'b0, '0);
      queue_cmd(KIND_TARGET, '0, 1'b0, 16'd65534);
      queue_cmd(KIND_LAST, 16'hFFFF, 1'b1, 16'd65534);
      queue_cmd(KIND_CLEAR, '0, 1'b0, '0);
      wait_drained();

      // smallest modulus, fastest period, half-way ties both ways
      csr_write(REG_STEPS_PER_REV, 32'd2);
      csr_write(REG_STEP_PERIOD, 32'd1);
      @(negedge clock);
      queue_cmd(KIND_TURN, 16'd3, 1'b1, '0);
      queue_cmd(KIND_TICK, '0, 1'b0, '0);
      queue_cmd(KIND_TICK, '0, 1'b0, '0);
      queue_cmd(KIND_TARGET, '0, 1'b0, 16'd1);
      queue_cmd(KIND_TICK, '0, 1'b0, '0);
      queue_cmd(KIND_TARGET, '0, 1'b0, 16'd0);
      queue_cmd(KIND_TICK, '0, 1'b0, '0);
      wait_drained();

      // position left above a shrunken modulus, stepped both ways
      csr_write(REG_STEPS_PER_REV, 32'd65535);
      @(negedge clock);
      queue_cmd(KIND_TURN, 16'd2, 1'b0, '0);
      queue_cmd(KIND_TICK, '0, 1'b0, '0);
      queue_cmd(KIND_TICK, '0, 1'b0, '0);
      wait_drained();
      csr_write(REG_STEPS_PER_REV, 32'd50);
      @(negedge clock);
      queue_cmd(KIND_TURN, 16'd1, 1'b1, '0);
      queue_cmd(KIND_TICK, '0, 1'b0, '0);
      wait_drained();
      csr_write(REG_STEPS_PER_REV, 32'd65535);
      @(negedge clock);
      queue_cmd(KIND_TURN, 16'd2, 1'b0, '0);
      queue_cmd(KIND_TICK, '0, 1'b0, '0);
      queue_cmd(KIND_TICK, '0, 1'b0, '0);
      wait_drained();
      csr_write(REG_STEPS_PER_REV, 32'd50);
      @(negedge clock);
      queue_cmd(KIND_TURN, 16'd1, 1'b0, '0);
      queue_cmd(KIND_TICK, '0, 1'b0, '0);
      wait_drained();

      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               csr_write(REG_STEPS_PER_REV, 32'd65535);
               csr_write(REG_STEP_PERIOD, 32'd16777215);
            end
            1: begin
               csr_write(REG_STEPS_PER_REV, 32'd2);
               csr_write(REG_STEP_PERIOD, 32'd1);
            end
            2: begin
               csr_write(REG_STEPS_PER_REV, $urandom_range(3, 40));
               csr_write(REG_STEP_PERIOD, 32'd1);
            end
            default: begin
               csr_write(REG_STEPS_PER_REV,
                         ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(2, 300));
               csr_write(REG_STEP_PERIOD, $urandom_range(1, 4));
            end
         endcase
         @(negedge clock);
         send_idle = (ph == 1 || ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
         recv_idle = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
         for (half = 0; half < 2; half++) begin
            made = 0;
            while (made < 17) begin
               sel = $urandom_range(0, 99);
               n = 0;
               if (sel < 40) begin
                  r = $urandom_range(0, 9);
                  count = (r < 7) ? STEP_W'($urandom_range(0, 12)) :
                          (r < 9) ? STEP_W'($urandom_range(13, 400)) :
                                    STEP_W'($urandom_range(0, 65535));
                  queue_cmd(KIND_TURN, count, 1'($urandom_range(0, 1)), STEP_W'($urandom));
                  made++;
                  n = $urandom_range(1, 20);
               end else if (sel < 65) begin
                  tgt = ($urandom_range(0, 3) != 0) ?
                        STEP_W'($urandom_range(0, int'(cfg_steps_per_rev) - 1)) :
                        STEP_W'($urandom_range(0, 65534));
                  queue_cmd(KIND_TARGET, STEP_W'($urandom), 1'($urandom_range(0, 1)), tgt);
                  made++;
                  n = $urandom_range(1, 20);
               end else if (sel < 75) begin
                  queue_cmd(KIND_STOP, STEP_W'($urandom), 1'($urandom_range(0, 1)),
                            STEP_W'($urandom));
                  made++;
                  n = $urandom_range(0, 3);
               end else if (sel < 83) begin
                  queue_cmd(KIND_CLEAR, STEP_W'($urandom), 1'($urandom_range(0, 1)),
                            STEP_W'($urandom));
                  made++;
                  n = $urandom_range(0, 3);
               end else if (sel < 88) begin
                  kind = KIND_W'($urandom_range(int'(KIND_CLEAR) + 1, int'(KIND_LAST)));
                  queue_cmd(kind, STEP_W'($urandom), 1'($urandom_range(0, 1)),
                            STEP_W'($urandom));
               end else begin
                  n = $urandom_range(1, 30);
               end
               for (i = 0; i < n; i++)
                  queue_cmd(KIND_TICK, STEP_W'($urandom), 1'($urandom_range(0, 1)),
                            STEP_W'($urandom));
               made = made + n;
            end
            // long receiver hold while the sender keeps offering words
            if (ph == 1 && half == 0)
               hold_ask++;
            wait_drained();
         end
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin : run_limit
      #5000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
